// ===== sv/key_matrix_press_decoder_assert.svh =====
// Assertion helpers for the key matrix press decoder.
// Both forms are disabled while reset is high.
`ifndef KEY_MATRIX_PRESS_DECODER_ASSERT_SVH
`define KEY_MATRIX_PRESS_DECODER_ASSERT_SVH

// Same-cycle implication.
`define KMPD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kmpd assertion failed");

// Next-cycle implication.
`define KMPD_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kmpd assertion failed");

`endif

// ===== sv/kmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmpd_pkg
// Shared types, matrix geometry and key code tables for the press decoder.
// ----------------------------------------------------------------------------
package kmpd_pkg;

   localparam int ROW_COUNT    = 6;
   localparam int COLUMN_COUNT = 10;
   localparam int KEY_COUNT    = ROW_COUNT * COLUMN_COUNT;
   localparam int KEY_IDX_W    = $clog2(KEY_COUNT);
   localparam int SHIFT_BIT    = 3;
   localparam int SYMBOL_BIT   = 4;
   localparam int CODE_W       = 8;

   typedef logic [KEY_COUNT-1:0] scan_type;
   typedef logic [CODE_W-1:0]    code_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;

   localparam code_type NO_KEY_CODE = '0;

   // New presses of one scan, with the modifier state taken from that scan
   typedef struct packed {
      scan_type fresh;
      logic     shift;
      logic     symbol;
   } press_type;

   // Tables are row-major: index row*COLUMN_COUNT + col
   localparam code_type PLAIN_CODES [KEY_COUNT] = '{
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h08,
      8'h00, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h05, 8'h00, 8'h04,
      8'h00, 8'h0d, 8'h00, 8'h00, 8'h20, 8'h2c, 8'h2e, 8'h6d, 8'h02, 8'h03,
      8'hf0, 8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9
   };

   localparam code_type SHIFTED_CODES [KEY_COUNT] = '{
      8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h08,
      8'h00, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h05, 8'h00, 8'h04,
      8'h00, 8'h0d, 8'h00, 8'h00, 8'h5f, 8'h2c, 8'h2e, 8'h4d, 8'h02, 8'h03,
      8'hf0, 8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9
   };

   localparam code_type SYMBOL_CODES [KEY_COUNT] = '{
      8'h21, 8'h32, 8'h33, 8'h24, 8'h25, 8'h36, 8'h27, 8'h22, 8'h28, 8'h29,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h5b, 8'h5d,
      8'h3d, 8'h2b, 8'h2d, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h3a, 8'h3f, 8'h08,
      8'h00, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h05, 8'h00, 8'h04,
      8'h00, 8'h0d, 8'h00, 8'h00, 8'h01, 8'h3c, 8'h3e, 8'h6d, 8'h02, 8'h03,
      8'hf0, 8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9
   };

endpackage

// ===== sv/kmpd_lookup.sv =====
// ----------------------------------------------------------------------------
// kmpd_lookup
// Picks the last new press in column-major order and maps it to a key code.
// ----------------------------------------------------------------------------
module kmpd_lookup import kmpd_pkg::*; (
   input  press_type press,
   output code_type  key_code
);

   key_idx_type pick;
   logic        found;

   // Later bits overwrite earlier ones, so the last press in scan order wins
   always_comb begin
      pick  = '0;
      found = 1'b0;
      for (int col = 0; col < COLUMN_COUNT; col++) begin
         for (int row = 0; row < ROW_COUNT; row++) begin
            if (press.fresh[col*ROW_COUNT + row]) begin
               pick  = KEY_IDX_W'(row*COLUMN_COUNT + col);
               found = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (!found) begin
         key_code = NO_KEY_CODE;
      end else if (press.shift) begin
         key_code = SHIFTED_CODES[pick];
      end else if (press.symbol) begin
         key_code = SYMBOL_CODES[pick];
      end else begin
         key_code = PLAIN_CODES[pick];
      end
   end

endmodule

// ===== sv/key_matrix_press_decoder.sv =====
// An accepted scan's new presses are registered in the press stage, then its key code in the output stage.
// Throughput: one scan per cycle; a held result stalls only once the press stage is full.
// The priority pick and table lookup sit between these two registers.
// Reset clears the stored scan to no key down and empties both stages.
// ----------------------------------------------------------------------------
// key_matrix_press_decoder
// Edge-detects key matrix scans and, per scan, emits the code of its last new press or no key code.
// ----------------------------------------------------------------------------
`include "key_matrix_press_decoder_assert.svh"

module key_matrix_press_decoder import kmpd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  scan_type req_key_matrix,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output code_type rsp_key_code
);

   localparam scan_type MODIFIER_MASK = scan_type'((1 << SHIFT_BIT) | (1 << SYMBOL_BIT));

   scan_type  prev_ff;
   scan_type  prev_in;
   press_type press_ff;
   press_type press_in;
   logic      press_valid_ff;
   logic      press_valid_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   code_type  rsp_code_ff;
   code_type  rsp_code_in;
   code_type  lookup_code;
   logic      req_take;
   logic      out_free;
   logic      press_move;
   logic      fresh_modifier;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign press_move = press_valid_ff && out_free;
   assign req_ready  = !press_valid_ff || out_free;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      prev_in        = prev_ff;
      press_in       = press_ff;
      press_valid_in = press_valid_ff;
      if (req_take) begin
         prev_in        = req_key_matrix;
         press_in.fresh = req_key_matrix & ~prev_ff & ~MODIFIER_MASK;
         press_in.shift = req_key_matrix[SHIFT_BIT];
         press_in.symbol = req_key_matrix[SYMBOL_BIT];
         press_valid_in = 1'b1;
      end else if (press_move) begin
         press_valid_in = 1'b0;
      end
   end

   kmpd_lookup u_lookup (
      .press    (press_ff),
      .key_code (lookup_code)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      if (press_move) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = lookup_code;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= '0;
         press_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_ff        <= prev_in;
         press_valid_ff <= press_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      press_ff    <= press_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;

   assign fresh_modifier = press_ff.fresh[SHIFT_BIT] || press_ff.fresh[SYMBOL_BIT];

   `KMPD_ASSERT_NXT(a_press_held_on_stall, press_valid_ff && rsp_valid_ff && !rsp_ready, press_valid_ff)
   `KMPD_ASSERT_NXT(a_press_reaches_output, press_move, rsp_valid_ff)
   `KMPD_ASSERT_IMP(a_ready_low_when_full, !req_ready, press_valid_ff && rsp_valid_ff && !rsp_ready)
   `KMPD_ASSERT_IMP(a_modifiers_never_fresh, press_valid_ff, !fresh_modifier)

endmodule
